// ----- design/fss_pkg.sv -----
// Package for the slot scheduler: field widths, operation and register codes,
// and the control, status and result structs shared between the modules.
// No dependencies.
`default_nettype none

package fss_pkg;

    localparam int MEMBERS_DEF     = 64;
    localparam int LENGTH_BITS_DEF = 16;

    localparam int MEMBER_W   = 6;
    localparam int MSG_W      = 16;
    localparam int LIMIT_W    = 16;
    localparam int OP_W       = 2;
    localparam int WAIT_CNT_W = 7;
    localparam int SUM_W      = 22;
    localparam int unsigned SUM_MAX = 4194303;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ROUND_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MEMBER = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_ROUND = 2'd2
    } t_op;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic                  speaker_valid;
        logic [MEMBER_W-1:0]   speaker_index;
        logic                  local_slot_open;
        logic                  local_status_changed;
        logic                  request_accepted;
        logic [WAIT_CNT_W-1:0] waiting_count;
        logic [SUM_W-1:0]      total_pending_length;
    } t_result;

endpackage

`default_nettype wire

// ----- design/fss_queue.sv -----
// Wait queue: member/length memory with head and tail pointers and fill count.
// Head entry is read ahead into a register so it is ready when popped. Uses fss_pkg.
`default_nettype none

module fss_queue #(
    parameter int MEMBERS     = fss_pkg::MEMBERS_DEF,
    parameter int LENGTH_BITS = fss_pkg::LENGTH_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  fss_pkg::t_q_ctl                       i_ctl,
    input  wire [fss_pkg::MEMBER_W-1:0]           i_wr_member,
    input  wire [LENGTH_BITS-1:0]                 i_wr_length,
    output fss_pkg::t_q_stat                      o_stat,
    output logic [$clog2(MEMBERS+1)-1:0]          o_fill,
    output logic [fss_pkg::MEMBER_W-1:0]          o_head_member,
    output logic [LENGTH_BITS-1:0]                o_head_length
);
    import fss_pkg::*;

    localparam int QP_W   = $clog2(MEMBERS);
    localparam int FILL_W = $clog2(MEMBERS + 1);

    logic [MEMBER_W-1:0]    mem_member [MEMBERS];
    logic [LENGTH_BITS-1:0] mem_length [MEMBERS];

    logic [QP_W-1:0]   r_head, r_tail, n_head, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;

    logic [MEMBER_W-1:0]    r_rd_member, r_byp_member;
    logic [LENGTH_BITS-1:0] r_rd_length, r_byp_length;
    logic                   r_byp;

    function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
        ptr_inc = (p == QP_W'(MEMBERS - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_head = i_ctl.pop  ? ptr_inc(r_head) : r_head;
        n_tail = i_ctl.push ? ptr_inc(r_tail) : r_tail;
        n_fill = r_fill + FILL_W'(i_ctl.push) - FILL_W'(i_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // memory: one write port at the tail, registered read of the next head
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem_member[r_tail] <= i_wr_member;
            mem_length[r_tail] <= i_wr_length;
        end
        r_rd_member <= mem_member[n_head];
        r_rd_length <= mem_length[n_head];
    end

    // a word written where the head will be next cycle bypasses the memory
    always_ff @(posedge i_clk) begin
        r_byp        <= i_ctl.push && (r_tail == n_head);
        r_byp_member <= i_wr_member;
        r_byp_length <= i_wr_length;
    end

    assign o_head_member = r_byp ? r_byp_member : r_rd_member;
    assign o_head_length = r_byp ? r_byp_length : r_rd_length;
    assign o_fill        = r_fill;
    assign o_stat        = '{empty: (r_fill == '0), full: (r_fill == FILL_W'(MEMBERS))};

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !o_stat.full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> !o_stat.empty)
        else $error("pop from empty queue");
    a_fill_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.empty && !o_stat.full) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

endmodule

`default_nettype wire

// ----- design/fss_slot.sv -----
// Slot state and per-word decision: holder, round timer, pending length,
// waiting bitmap and local status; builds the result word. Uses fss_pkg.
`default_nettype none

module fss_slot #(
    parameter int MEMBERS     = fss_pkg::MEMBERS_DEF,
    parameter int LENGTH_BITS = fss_pkg::LENGTH_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_fire,
    input  wire [fss_pkg::OP_W-1:0]            i_op,
    input  wire [fss_pkg::MEMBER_W-1:0]        i_idx,
    input  wire [fss_pkg::LIMIT_W-1:0]         i_round_limit,
    input  wire [fss_pkg::MEMBER_W-1:0]        i_local_member,
    input  fss_pkg::t_q_stat                   i_q_stat,
    input  wire [$clog2(MEMBERS+1)-1:0]        i_fill,
    input  wire [fss_pkg::MEMBER_W-1:0]        i_head_member,
    input  wire [LENGTH_BITS-1:0]              i_head_length,
    output fss_pkg::t_q_ctl                    o_q_ctl,
    output fss_pkg::t_result                   o_result
);
    import fss_pkg::*;

    localparam int MIDX_W = $clog2(MEMBERS);
    localparam int FILL_W = $clog2(MEMBERS + 1);

    logic                   r_hv, n_hv;
    logic [MEMBER_W-1:0]    r_hidx, n_hidx;
    logic [LIMIT_W-1:0]     r_left, n_left;
    logic [LENGTH_BITS-1:0] r_pending, n_pending;
    logic [MEMBERS-1:0]     r_waiting, n_waiting;
    logic                   r_local, n_local;

    logic              in_range, is_holder, rel, grant, push_v, pop_v;
    logic              changed, accepted;
    logic [MIDX_W-1:0] ix, hix;
    logic [FILL_W-1:0] fill_after;

    always_comb begin
        n_hv      = r_hv;
        n_hidx    = r_hidx;
        n_left    = r_left;
        n_pending = r_pending;
        n_waiting = r_waiting;
        n_local   = r_local;
        rel       = 1'b0;
        grant     = 1'b0;
        push_v    = 1'b0;
        changed   = 1'b0;
        accepted  = 1'b0;
        ix        = MIDX_W'(i_idx);
        hix       = MIDX_W'(i_head_member);
        in_range  = (32'(i_idx) < MEMBERS);
        is_holder = r_hv && (i_idx == r_hidx);

        unique case (i_op)
            OP_OPEN: begin
                if (in_range && !is_holder && !r_waiting[ix] && !i_q_stat.full) begin
                    accepted     = 1'b1;
                    push_v       = 1'b1;
                    n_waiting[ix] = 1'b1;
                end
            end
            OP_CLOSE: begin
                if (in_range && is_holder) begin
                    accepted = 1'b1;
                    rel      = 1'b1;
                end
            end
            OP_ROUND: begin
                // timer runs out: hand over only when someone waits
                if (i_round_limit != '0 && r_hv) begin
                    if (r_left == '0) begin
                        rel = !i_q_stat.empty;
                    end else begin
                        n_left = r_left - 1'b1;
                    end
                end
                grant = (!r_hv || rel) && !i_q_stat.empty;
            end
            default: ;
        endcase

        if (rel) begin
            n_hv      = 1'b0;
            n_hidx    = '0;
            n_pending = '0;
            if (r_hidx == i_local_member) begin
                n_local = 1'b0;
                changed = 1'b1;
            end
        end

        if (grant) begin
            n_hv           = 1'b1;
            n_hidx         = i_head_member;
            n_pending      = i_head_length;
            n_left         = i_round_limit;
            n_waiting[hix] = 1'b0;
            if (i_head_member == i_local_member) begin
                n_local = 1'b1;
                changed = 1'b1;
            end
        end

        pop_v      = grant;
        fill_after = i_fill + FILL_W'(push_v) - FILL_W'(pop_v);

        o_q_ctl.push = i_fire && push_v;
        o_q_ctl.pop  = i_fire && pop_v;

        o_result.speaker_valid        = n_hv;
        o_result.speaker_index        = n_hv ? n_hidx : '0;
        o_result.local_slot_open      = n_local;
        o_result.local_status_changed = changed;
        o_result.request_accepted     = accepted;
        o_result.waiting_count        = WAIT_CNT_W'(fill_after);
        // pending is zero whenever the slot is free
        o_result.total_pending_length = (32'(n_pending) > 32'(SUM_MAX)) ?
                                        SUM_W'(SUM_MAX) : SUM_W'(n_pending);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv      <= 1'b0;
            r_hidx    <= '0;
            r_left    <= '0;
            r_pending <= '0;
            r_waiting <= '0;
            r_local   <= 1'b0;
        end else if (i_fire) begin
            r_hv      <= n_hv;
            r_hidx    <= n_hidx;
            r_left    <= n_left;
            r_pending <= n_pending;
            r_waiting <= n_waiting;
            r_local   <= n_local;
        end
    end

endmodule

`default_nettype wire

// ----- design/fifo_slot_scheduler_with_time_limit_core.sv -----
// Shared speaking-slot scheduler, first-come order with optional round limit.
// Top level: input and result registers, config registers; uses fss_pkg,
// fss_queue and fss_slot.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries one word: operation
//   (open, close, round completed), member index and message length.
//   Output channel (o_out_valid/i_out_ready) returns one result word per
//   input word: current speaker, local slot status, accept flag, queue
//   depth and pending length.
//   Path: an accepted word waits in the input register; its result is
//   written to the result register and offered from there until taken.
//   Throughput: one word per cycle while results are taken; the whole
//   update is one pass of logic between the input register and the result
//   register, with the queue head prefetched from its memory into a register.
//   Receiver stall: the result register holds; the input register takes one
//   more word if it is empty, then o_in_ready drops until the result is taken.
//   Configuration: i_cfg_we with i_cfg_index writes round_limit (0) or
//   local_member (1); write only while the block is idle.
//   Reset: synchronous, active low; no speaker, empty queue, limit 0.
`default_nettype none

module fifo_slot_scheduler_with_time_limit_core #(
    parameter int MEMBERS     = fss_pkg::MEMBERS_DEF,
    parameter int LENGTH_BITS = fss_pkg::LENGTH_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,

    input  wire                                i_cfg_we,
    input  wire [fss_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [fss_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire [fss_pkg::OP_W-1:0]            i_operation,
    input  wire [fss_pkg::MEMBER_W-1:0]        i_member_index,
    input  wire [fss_pkg::MSG_W-1:0]           i_message_length,

    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic                               o_speaker_valid,
    output logic [fss_pkg::MEMBER_W-1:0]       o_speaker_index,
    output logic                               o_local_slot_open,
    output logic                               o_local_status_changed,
    output logic                               o_request_accepted,
    output logic [fss_pkg::WAIT_CNT_W-1:0]     o_waiting_count,
    output logic [fss_pkg::SUM_W-1:0]          o_total_pending_length
);
    import fss_pkg::*;

    localparam int FILL_W = $clog2(MEMBERS + 1);

    logic [LIMIT_W-1:0]  r_round_limit;
    logic [MEMBER_W-1:0] r_local_member;

    logic                   r_in_valid;
    logic [OP_W-1:0]        r_in_op;
    logic [MEMBER_W-1:0]    r_in_idx;
    logic [LENGTH_BITS-1:0] r_in_len;

    logic    r_out_valid;
    t_result r_res, res;

    logic fire;

    t_q_ctl                 q_ctl;
    t_q_stat                q_stat;
    logic [FILL_W-1:0]      q_fill;
    logic [MEMBER_W-1:0]    q_head_member;
    logic [LENGTH_BITS-1:0] q_head_length;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_limit  <= '0;
            r_local_member <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROUND_LIMIT:  r_round_limit  <= LIMIT_W'(i_cfg_data);
                REG_LOCAL_MEMBER: r_local_member <= i_cfg_data[MEMBER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op  <= i_operation;
            r_in_idx <= i_member_index;
            r_in_len <= LENGTH_BITS'(i_message_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    fss_queue #(
        .MEMBERS     (MEMBERS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (q_ctl),
        .i_wr_member   (r_in_idx),
        .i_wr_length   (r_in_len),
        .o_stat        (q_stat),
        .o_fill        (q_fill),
        .o_head_member (q_head_member),
        .o_head_length (q_head_length)
    );

    fss_slot #(
        .MEMBERS     (MEMBERS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_slot (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_op           (r_in_op),
        .i_idx          (r_in_idx),
        .i_round_limit  (r_round_limit),
        .i_local_member (r_local_member),
        .i_q_stat       (q_stat),
        .i_fill         (q_fill),
        .i_head_member  (q_head_member),
        .i_head_length  (q_head_length),
        .o_q_ctl        (q_ctl),
        .o_result       (res)
    );

    assign o_out_valid            = r_out_valid;
    assign o_speaker_valid        = r_res.speaker_valid;
    assign o_speaker_index        = r_res.speaker_index;
    assign o_local_slot_open      = r_res.local_slot_open;
    assign o_local_status_changed = r_res.local_status_changed;
    assign o_request_accepted     = r_res.request_accepted;
    assign o_waiting_count        = r_res.waiting_count;
    assign o_total_pending_length = r_res.total_pending_length;

    a_round_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_op == OP_ROUND) |=> !o_request_accepted)
        else $error("round word flagged as accepted");
    a_no_speaker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_speaker_valid) |->
            (o_speaker_index == '0 && o_total_pending_length == '0))
        else $error("free slot with speaker index or pending length");
    a_queue_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_ctl.push && q_ctl.pop) && (!(q_ctl.push || q_ctl.pop) || fire))
        else $error("queue update outside a processed word");

endmodule

`default_nettype wire

// ----- test/fifo_slot_scheduler_with_time_limit_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the slot scheduler core: directed and random words
// with random idling on both channels, checked against a cycle-free predictor.
// Depends on fss_pkg and fifo_slot_scheduler_with_time_limit_core.

module fifo_slot_scheduler_with_time_limit_core_tb;

    import fss_pkg::*;

    localparam int MEMBERS        = MEMBERS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int PHASES         = 6;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation;
    logic [MEMBER_W-1:0]   i_member_index;
    logic [MSG_W-1:0]      i_message_length;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_speaker_valid;
    logic [MEMBER_W-1:0]   o_speaker_index;
    logic                  o_local_slot_open;
    logic                  o_local_status_changed;
    logic                  o_request_accepted;
    logic [WAIT_CNT_W-1:0] o_waiting_count;
    logic [SUM_W-1:0]      o_total_pending_length;

    bit quiet;
    int idle_cycles = 0;

    fifo_slot_scheduler_with_time_limit_core DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_operation            (i_operation),
        .i_member_index         (i_member_index),
        .i_message_length       (i_message_length),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_speaker_valid        (o_speaker_valid),
        .o_speaker_index        (o_speaker_index),
        .o_local_slot_open      (o_local_slot_open),
        .o_local_status_changed (o_local_status_changed),
        .o_request_accepted     (o_request_accepted),
        .o_waiting_count        (o_waiting_count),
        .o_total_pending_length (o_total_pending_length)
    );

    // Tracks the slot, the wait queue and pending lengths; holds expected results.
    class slot_scoreboard;
        bit [LIMIT_W-1:0]    round_limit;
        bit [MEMBER_W-1:0]   local_member;
        bit [MEMBER_W-1:0]   fifo_member [MEMBERS];
        bit [MSG_W-1:0]      fifo_length [MEMBERS];
        int                  head;
        int                  tail;
        int                  fill;
        bit                  is_waiting [MEMBERS];
        bit                  holder_valid;
        bit [MEMBER_W-1:0]   holder_index;
        bit [LIMIT_W-1:0]    rounds_left;
        bit [MSG_W-1:0]      member_pending [MEMBERS];
        bit [SUM_W-1:0]      pending_sum;
        bit                  local_open;
        t_result             expected_q [$];
        int                  errors;

        function new();
            round_limit  = '0;
            local_member = '0;
            head = 0;
            tail = 0;
            fill = 0;
            holder_valid = 1'b0;
            holder_index = '0;
            rounds_left  = '0;
            pending_sum  = '0;
            local_open   = 1'b0;
            errors       = 0;
            for (int i = 0; i < MEMBERS; i++) begin
                fifo_member[i]    = '0;
                fifo_length[i]    = '0;
                is_waiting[i]     = 1'b0;
                member_pending[i] = '0;
            end
        endfunction

        // Drops the holder; returns 1 when the local slot closes.
        function bit release_slot();
            bit changed;
            changed = 1'b0;
            if (member_pending[holder_index] >= pending_sum)
                pending_sum = '0;
            else
                pending_sum = pending_sum - member_pending[holder_index];
            member_pending[holder_index] = '0;
            if (holder_index == local_member) begin
                local_open = 1'b0;
                changed = 1'b1;
            end
            holder_valid = 1'b0;
            holder_index = '0;
            return changed;
        endfunction

        function void note_input(bit [OP_W-1:0] op, bit [MEMBER_W-1:0] idx,
                                 bit [MSG_W-1:0] len);
            t_result          r;
            bit               changed;
            bit               accepted;
            bit [MEMBER_W-1:0] m;
            bit [SUM_W:0]     sum;
            changed  = 1'b0;
            accepted = 1'b0;
            if (op == OP_OPEN) begin
                if (!(holder_valid && idx == holder_index) && !is_waiting[idx] &&
                    fill < MEMBERS) begin
                    fifo_member[tail] = idx;
                    fifo_length[tail] = len;
                    tail = (tail + 1) % MEMBERS;
                    fill++;
                    is_waiting[idx] = 1'b1;
                    accepted = 1'b1;
                end
            end else if (op == OP_CLOSE) begin
                if (holder_valid && idx == holder_index) begin
                    changed  = release_slot();
                    accepted = 1'b1;
                end
            end else if (op == OP_ROUND) begin
                if (round_limit != 0 && holder_valid) begin
                    // timer at zero only ends the turn when someone is waiting
                    if (rounds_left == 0) begin
                        if (fill != 0)
                            changed = release_slot() || changed;
                    end else begin
                        rounds_left--;
                    end
                end
                if (!holder_valid && fill != 0) begin
                    m = fifo_member[head];
                    member_pending[m] = fifo_length[head];
                    head = (head + 1) % MEMBERS;
                    fill--;
                    is_waiting[m] = 1'b0;
                    holder_valid = 1'b1;
                    holder_index = m;
                    sum = pending_sum + member_pending[m];
                    pending_sum = (sum > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum[SUM_W-1:0];
                    rounds_left = round_limit;
                    if (m == local_member) begin
                        local_open = 1'b1;
                        changed = 1'b1;
                    end
                end
            end
            r.speaker_valid        = holder_valid;
            r.speaker_index        = holder_valid ? holder_index : '0;
            r.local_slot_open      = local_open;
            r.local_status_changed = changed;
            r.request_accepted     = accepted;
            r.waiting_count        = fill[WAIT_CNT_W-1:0];
            r.total_pending_length = pending_sum;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
                         want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word: expected none, actual %p", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("speaker_valid", want.speaker_valid, got.speaker_valid);
            compare_field("speaker_index", want.speaker_index, got.speaker_index);
            compare_field("local_slot_open", want.local_slot_open, got.local_slot_open);
            compare_field("local_status_changed", want.local_status_changed,
                          got.local_status_changed);
            compare_field("request_accepted", want.request_accepted, got.request_accepted);
            compare_field("waiting_count", want.waiting_count, got.waiting_count);
            compare_field("total_pending_length", want.total_pending_length,
                          got.total_pending_length);
        endfunction
    endclass

    slot_scoreboard sb;

    always #5 i_clk = ~i_clk;

    // accept/compare on the rising edge, plus watchdog on handshake activity
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid && o_in_ready)
                sb.note_input(i_operation, i_member_index, i_message_length);
            if (o_out_valid && i_out_ready)
                sb.check_result('{o_speaker_valid, o_speaker_index, o_local_slot_open,
                                  o_local_status_changed, o_request_accepted,
                                  o_waiting_count, o_total_pending_length});
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // result side: random back-pressure, always ready in quiet phases
    initial begin
        int hold;
        hold = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (quiet || $urandom_range(0, 99) < 65) begin
                i_out_ready <= 1'b1;
                hold = quiet ? 0 : $urandom_range(0, 6);
            end else begin
                i_out_ready <= 1'b0;
                hold = pick_gap();
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [OP_W-1:0] op, input logic [MEMBER_W-1:0] idx,
                             input logic [MSG_W-1:0] len);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_member_index   <= idx;
        i_message_length <= len;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(input logic [LIMIT_W-1:0] limit,
                             input logic [MEMBER_W-1:0] member);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_ROUND_LIMIT;
        i_cfg_data  <= limit;
        @(negedge i_clk);
        i_cfg_index <= REG_LOCAL_MEMBER;
        i_cfg_data  <= CFG_DATA_W'(member);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        sb.round_limit  = limit;
        sb.local_member = member;
    endtask

    // small pool keeps duplicates, local matches and re-queues frequent
    function automatic logic [MEMBER_W-1:0] pick_member();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return MEMBER_W'($urandom_range(0, 7));
        else if (r < 90)
            return MEMBER_W'($urandom_range(0, 63));
        else
            return 6'd63;
    endfunction

    task automatic send_random_word();
        int                r;
        logic [OP_W-1:0]   op;
        logic [MEMBER_W-1:0] idx;
        logic [MSG_W-1:0]  len;
        r = $urandom_range(0, 99);
        idx = pick_member();
        if (r < 35)
            op = OP_OPEN;
        else if (r < 60)
            op = OP_CLOSE;
        else if (r < 95)
            op = OP_ROUND;
        else
            op = OP_UNUSED;
        if (op == OP_CLOSE && sb.holder_valid && $urandom_range(0, 99) < 80)
            idx = sb.holder_index;
        r = $urandom_range(0, 99);
        if (r < 5)
            len = '0;
        else if (r < 10)
            len = '1;
        else
            len = MSG_W'($urandom_range(0, 65535));
        send_word(op, idx, len);
    endtask

    initial begin
        logic [LIMIT_W-1:0]  limit;
        logic [MEMBER_W-1:0] member;
        sb = new();
        quiet            = 1'b1;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_operation      = '0;
        i_member_index   = '0;
        i_message_length = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: no limit, local member 0
        configure(16'd0, 6'd0);
        send_word(OP_UNUSED, 6'd63, 16'hFFFF);
        send_word(OP_CLOSE, 6'd5, 16'd0);      // close with the slot free
        send_word(OP_ROUND, 6'd0, 16'd0);      // round with empty queue
        send_word(OP_OPEN, 6'd0, 16'hFFFF);
        send_word(OP_OPEN, 6'd0, 16'd1);       // already waiting
        send_word(OP_OPEN, 6'd63, 16'd0);
        send_word(OP_OPEN, 6'd42, 16'h5555);
        send_word(OP_ROUND, 6'd0, 16'd0);      // local member takes the slot
        send_word(OP_OPEN, 6'd0, 16'd7);       // open from the holder
        send_word(OP_CLOSE, 6'd63, 16'd0);     // close from a non-holder
        send_word(OP_ROUND, 6'd0, 16'd0);      // no limit, holder stays
        send_word(OP_CLOSE, 6'd0, 16'd0);
        send_word(OP_ROUND, 6'd0, 16'd0);
        send_word(OP_UNUSED, 6'd0, 16'd0);
        wait_drained();

        // limit set while 63 speaks with its timer already at zero
        configure(16'd1, 6'd63);
        send_word(OP_ROUND, 6'd1, 16'd0);
        send_word(OP_ROUND, 6'd2, 16'd0);
        send_word(OP_ROUND, 6'd3, 16'd0);      // timer at zero, nobody waiting
        send_word(OP_OPEN, 6'd63, 16'hAAAA);
        send_word(OP_ROUND, 6'd0, 16'd0);
        send_word(OP_CLOSE, 6'd63, 16'hFFFF);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin limit = 16'd0;     member = MEMBER_W'($urandom_range(0, 7)); end
                1: begin limit = 16'd1;     member = 6'd63; end
                2: begin limit = 16'hFFFF;  member = 6'd0; end
                3: begin limit = 16'd2;     member = MEMBER_W'($urandom_range(0, 7)); end
                4: begin
                    limit  = LIMIT_W'($urandom_range(1, 4));
                    member = MEMBER_W'($urandom_range(0, 7));
                end
                default: begin
                    limit  = LIMIT_W'($urandom_range(0, 65535));
                    member = MEMBER_W'($urandom_range(0, 63));
                end
            endcase
            configure(limit, member);
            quiet = (phase == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_word();
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (sb.expected_q.size() != 0) begin
            sb.errors++;
            $display("%0t: results missing: expected %0d more, actual 0", $time,
                     sb.expected_q.size());
        end
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/fss_pkg.sv
design/fss_queue.sv
design/fss_slot.sv
design/fifo_slot_scheduler_with_time_limit_core.sv
test/fifo_slot_scheduler_with_time_limit_core_tb.sv
